// ----- design/ccrg_pkg.sv -----
package ccrg_pkg;

   localparam int ENTRIES      = 16;
   localparam int UID_BITS     = 56;
   localparam int COUNTER_BITS = 32;

   localparam int IDX_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_BITS = $clog2(ENTRIES + 1);
   localparam int CMP_BITS = (UID_BITS > COUNTER_BITS) ? UID_BITS : COUNTER_BITS;

   localparam int CSR_ADDR_BITS = 2;
   localparam int CSR_DATA_BITS = 32;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_MAX_COUNTER = '0;

   // entry status codes
   localparam logic [1:0] STAT_OK          = 2'd0;
   localparam logic [1:0] STAT_BLOCKED     = 2'd1;
   localparam logic [1:0] STAT_COMPROMISED = 2'd2;

   // request function codes
   localparam logic FUNC_PRESENT = 1'b0;
   localparam logic FUNC_BLOCK   = 1'b1;

   // deny reason codes
   localparam logic [2:0] RSN_NONE        = 3'd0;
   localparam logic [2:0] RSN_TIME        = 3'd1;
   localparam logic [2:0] RSN_COMPROMISED = 3'd2;
   localparam logic [2:0] RSN_BLOCKED     = 3'd3;
   localparam logic [2:0] RSN_REPLAY      = 3'd4;
   localparam logic [2:0] RSN_REGRESSION  = 3'd5;
   localparam logic [2:0] RSN_OVERFLOW    = 3'd6;
   localparam logic [2:0] RSN_FULL        = 3'd7;

   typedef struct packed {
      logic                    func;
      logic [UID_BITS-1:0]     card_uid;
      logic [COUNTER_BITS-1:0] card_counter;
      logic                    time_allowed;
   } req_type;

   typedef struct packed {
      logic                    allow;
      logic [2:0]              reason;
      logic [COUNTER_BITS-1:0] prior_count;
      logic [COUNTER_BITS-1:0] next_count;
      logic                    entry_written;
   } rsp_type;

   typedef struct packed {
      logic [UID_BITS-1:0]     uid;
      logic [COUNTER_BITS-1:0] counter;
      logic [1:0]              status;
   } entry_type;

   typedef struct packed {
      logic                en;
      logic [IDX_BITS-1:0] addr;
      entry_type           entry;
   } tbl_wr_type;

   typedef struct packed {
      logic valid;
      entry_type entry;
   } tbl_rd_type;

   typedef struct packed {
      logic eq;
      logic lt;
   } cmp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_CMP_HIT,
      ST_CMP_MAX,
      ST_DECIDE
   } state_type;

endpackage

// ----- design/card_counter_replay_guard.sv -----
// Card counter replay guard.
// req_ channel: one transfer per card event (present or block), valid/ready.
// rsp_ channel: exactly one decision transfer per request, valid/ready.
// csr_ port: APB-style, one register (max_counter) at byte address 0;
//   reads return its value. The user must write it only while the block is
//   idle; the block itself does not enforce this.
// A request runs through a table scan, one slot read per cycle through the
//   single registered table port, then two counter compares on the shared
//   comparator and a decide step.
// req_ready is high only while the sequencer is idle, so a new request is
//   not taken until the previous one has left its decide step.
// Stall: the decision sits in an output register; a new request is taken
//   while it waits, and that request holds in its decide step until the
//   register frees up.
// Reset: the table is emptied (valid bits cleared), max_counter returns to
//   all ones, and no response is pending.
module card_counter_replay_guard (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  ccrg_pkg::req_type                      req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output ccrg_pkg::rsp_type                      rsp_data,
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [ccrg_pkg::CSR_ADDR_BITS-1:0]     csr_paddr,
   input  logic [ccrg_pkg::CSR_DATA_BITS-1:0]     csr_pwdata,
   output logic [ccrg_pkg::CSR_DATA_BITS-1:0]     csr_prdata,
   output logic                                   csr_pready
);

   // ---------------------------------------------------------------
   // Configuration register
   // ---------------------------------------------------------------
   logic [ccrg_pkg::COUNTER_BITS-1:0] max_counter_ff;
   logic                              csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_counter_ff <= '1;
      end else if (csr_wr && (csr_paddr == ccrg_pkg::CSR_MAX_COUNTER)) begin
         max_counter_ff <= csr_pwdata[ccrg_pkg::COUNTER_BITS-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr == ccrg_pkg::CSR_MAX_COUNTER) begin
         csr_prdata = ccrg_pkg::CSR_DATA_BITS'(max_counter_ff);
      end
   end

   // ---------------------------------------------------------------
   // Sequencer state and datapath registers
   // ---------------------------------------------------------------
   ccrg_pkg::state_type state_ff, state_in;

   ccrg_pkg::req_type                  req_ff, req_in;
   logic [ccrg_pkg::CNT_BITS-1:0]      scan_cnt_ff, scan_cnt_in;   // slots issued
   logic                               cmp_vld_ff, cmp_vld_in;     // read data valid
   logic [ccrg_pkg::IDX_BITS-1:0]      cmp_idx_ff, cmp_idx_in;     // slot of read data
   logic                               found_ff, found_in;
   logic [ccrg_pkg::IDX_BITS-1:0]      hit_idx_ff, hit_idx_in;
   logic [ccrg_pkg::COUNTER_BITS-1:0]  stored_ff, stored_in;
   logic [1:0]                         status_ff, status_in;
   logic                               free_found_ff, free_found_in;
   logic [ccrg_pkg::IDX_BITS-1:0]      free_idx_ff, free_idx_in;
   logic                               ctr_eq_ff, ctr_eq_in;      // card == stored
   logic                               ctr_lt_ff, ctr_lt_in;      // card <  stored
   logic                               ovf_ff, ovf_in;            // card >= max
   logic                               rsp_valid_ff, rsp_valid_in;
   ccrg_pkg::rsp_type                  rsp_ff, rsp_in;

   // table and comparator hookup
   logic [ccrg_pkg::IDX_BITS-1:0]      rd_addr;
   ccrg_pkg::tbl_rd_type               rd_data;
   ccrg_pkg::tbl_wr_type               tbl_wr;
   logic [ccrg_pkg::CMP_BITS-1:0]      cmp_a, cmp_b;
   ccrg_pkg::cmp_type                  cmp_res;

   logic                               scan_last;
   logic                               rsp_free;
   ccrg_pkg::rsp_type                  decision;
   ccrg_pkg::tbl_wr_type               decision_wr;

   ccrg_table u_table (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr      (tbl_wr)
   );

   ccrg_cmp u_cmp (
      .op_a   (cmp_a),
      .op_b   (cmp_b),
      .result (cmp_res)
   );

   assign scan_last = cmp_vld_ff
                      && (cmp_idx_ff == ccrg_pkg::IDX_BITS'(ccrg_pkg::ENTRIES - 1));
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign rd_addr   = scan_cnt_ff[ccrg_pkg::IDX_BITS-1:0];

   // ---------------------------------------------------------------
   // Decision, evaluated from the scan and compare results
   // ---------------------------------------------------------------
   always_comb begin
      logic [ccrg_pkg::COUNTER_BITS-1:0] ctr;
      logic                              do_allow;
      logic [ccrg_pkg::IDX_BITS-1:0]     slot;
      ctr      = req_ff.card_counter;
      do_allow = 1'b0;
      slot     = free_idx_ff;

      decision.allow         = 1'b0;
      decision.reason        = ccrg_pkg::RSN_NONE;
      decision.prior_count   = ctr;
      decision.next_count    = ctr;
      decision.entry_written = 1'b0;

      decision_wr.en            = 1'b0;
      decision_wr.addr          = hit_idx_ff;
      decision_wr.entry.uid     = req_ff.card_uid;
      decision_wr.entry.counter = stored_ff;
      decision_wr.entry.status  = ccrg_pkg::STAT_BLOCKED;

      if (req_ff.func == ccrg_pkg::FUNC_BLOCK) begin
         if (found_ff) begin
            // keep the counter, mark blocked
            decision.reason        = ccrg_pkg::RSN_BLOCKED;
            decision.prior_count   = stored_ff;
            decision.next_count    = stored_ff;
            decision.entry_written = 1'b1;
            decision_wr.en         = 1'b1;
         end else if (!free_found_ff) begin
            decision.reason = ccrg_pkg::RSN_FULL;
         end else begin
            decision.reason           = ccrg_pkg::RSN_BLOCKED;
            decision.entry_written    = 1'b1;
            decision_wr.en            = 1'b1;
            decision_wr.addr          = free_idx_ff;
            decision_wr.entry.counter = ctr;
         end
      end else if (!req_ff.time_allowed) begin
         decision.reason = ccrg_pkg::RSN_TIME;
      end else if (found_ff) begin
         decision.prior_count = stored_ff;
         decision.next_count  = stored_ff;
         // unused status code 3 falls in with compromised
         if (status_ff >= ccrg_pkg::STAT_COMPROMISED) begin
            decision.reason = ccrg_pkg::RSN_COMPROMISED;
         end else if (status_ff == ccrg_pkg::STAT_BLOCKED) begin
            decision.reason = ccrg_pkg::RSN_BLOCKED;
         end else if (ctr_eq_ff || ctr_lt_ff) begin
            decision.reason          = ctr_eq_ff ? ccrg_pkg::RSN_REPLAY
                                                 : ccrg_pkg::RSN_REGRESSION;
            decision.entry_written   = 1'b1;
            decision_wr.en           = 1'b1;
            decision_wr.entry.status = ccrg_pkg::STAT_COMPROMISED;
         end else if (ovf_ff) begin
            decision.reason = ccrg_pkg::RSN_OVERFLOW;
         end else begin
            do_allow = 1'b1;
            slot     = hit_idx_ff;
         end
      end else if (ovf_ff) begin
         decision.reason = ccrg_pkg::RSN_OVERFLOW;
      end else if (!free_found_ff) begin
         decision.reason = ccrg_pkg::RSN_FULL;
      end else begin
         do_allow = 1'b1;
      end

      if (do_allow) begin
         decision.allow            = 1'b1;
         decision.reason           = ccrg_pkg::RSN_NONE;
         decision.prior_count      = ctr;
         decision.next_count       = ctr + 1'b1;
         decision.entry_written    = 1'b1;
         decision_wr.en            = 1'b1;
         decision_wr.addr          = slot;
         decision_wr.entry.counter = ctr + 1'b1;
         decision_wr.entry.status  = ccrg_pkg::STAT_OK;
      end
   end

   // ---------------------------------------------------------------
   // Next state
   // ---------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ccrg_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = ccrg_pkg::ST_SCAN;
            end
         end
         ccrg_pkg::ST_SCAN: begin
            if (scan_last) begin
               state_in = ccrg_pkg::ST_CMP_HIT;
            end
         end
         ccrg_pkg::ST_CMP_HIT: state_in = ccrg_pkg::ST_CMP_MAX;
         ccrg_pkg::ST_CMP_MAX: state_in = ccrg_pkg::ST_DECIDE;
         ccrg_pkg::ST_DECIDE: begin
            if (rsp_free) begin
               state_in = ccrg_pkg::ST_IDLE;
            end
         end
         default: state_in = ccrg_pkg::ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------
   // Sequencer outputs and datapath next values
   // ---------------------------------------------------------------
   always_comb begin
      req_ready     = 1'b0;
      req_in        = req_ff;
      scan_cnt_in   = scan_cnt_ff;
      cmp_vld_in    = 1'b0;
      cmp_idx_in    = cmp_idx_ff;
      found_in      = found_ff;
      hit_idx_in    = hit_idx_ff;
      stored_in     = stored_ff;
      status_in     = status_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      ctr_eq_in     = ctr_eq_ff;
      ctr_lt_in     = ctr_lt_ff;
      ovf_in        = ovf_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      tbl_wr        = decision_wr;
      tbl_wr.en     = 1'b0;
      cmp_a         = ccrg_pkg::CMP_BITS'(req_ff.card_uid);
      cmp_b         = ccrg_pkg::CMP_BITS'(rd_data.entry.uid);

      unique case (state_ff)
         ccrg_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               req_in        = req_data;
               scan_cnt_in   = '0;
               found_in      = 1'b0;
               free_found_in = 1'b0;
            end
         end
         ccrg_pkg::ST_SCAN: begin
            // issue one slot read per cycle, compare the slot read last cycle
            if (scan_cnt_ff != ccrg_pkg::CNT_BITS'(ccrg_pkg::ENTRIES)) begin
               scan_cnt_in = scan_cnt_ff + 1'b1;
               cmp_vld_in  = 1'b1;
               cmp_idx_in  = scan_cnt_ff[ccrg_pkg::IDX_BITS-1:0];
            end
            if (cmp_vld_ff) begin
               if (rd_data.valid && cmp_res.eq && !found_ff) begin
                  found_in   = 1'b1;
                  hit_idx_in = cmp_idx_ff;
                  stored_in  = rd_data.entry.counter;
                  status_in  = rd_data.entry.status;
               end
               if (!rd_data.valid && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in   = cmp_idx_ff;
               end
            end
         end
         ccrg_pkg::ST_CMP_HIT: begin
            cmp_a     = ccrg_pkg::CMP_BITS'(req_ff.card_counter);
            cmp_b     = ccrg_pkg::CMP_BITS'(stored_ff);
            ctr_eq_in = cmp_res.eq;
            ctr_lt_in = cmp_res.lt;
         end
         ccrg_pkg::ST_CMP_MAX: begin
            // counter above max-1, or max of zero, both reduce to card >= max
            cmp_a  = ccrg_pkg::CMP_BITS'(req_ff.card_counter);
            cmp_b  = ccrg_pkg::CMP_BITS'(max_counter_ff);
            ovf_in = !cmp_res.lt;
         end
         ccrg_pkg::ST_DECIDE: begin
            if (rsp_free) begin
               rsp_in       = decision;
               rsp_valid_in = 1'b1;
               tbl_wr       = decision_wr;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ccrg_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cmp_vld_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cmp_vld_ff   <= cmp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      scan_cnt_ff   <= scan_cnt_in;
      cmp_idx_ff    <= cmp_idx_in;
      found_ff      <= found_in;
      hit_idx_ff    <= hit_idx_in;
      stored_ff     <= stored_in;
      status_ff     <= status_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      ctr_eq_ff     <= ctr_eq_in;
      ctr_lt_ff     <= ctr_lt_in;
      ovf_ff        <= ovf_in;
      rsp_ff        <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- design/ccrg_table.sv -----
module ccrg_table (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [ccrg_pkg::IDX_BITS-1:0]     rd_addr,
   output ccrg_pkg::tbl_rd_type              rd_data,
   input  ccrg_pkg::tbl_wr_type              wr
);

   ccrg_pkg::entry_type              entry_mem_ff [ccrg_pkg::ENTRIES];
   logic [ccrg_pkg::ENTRIES-1:0]     valid_ff;
   ccrg_pkg::entry_type              rd_entry_ff;
   logic                             rd_valid_ff;

   // entry storage, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr.en) begin
         entry_mem_ff[wr.addr] <= wr.entry;
      end
      rd_entry_ff <= entry_mem_ff[rd_addr];
   end

   // valid bits live in flops so reset empties the table at once
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr.en) begin
            valid_ff[wr.addr] <= 1'b1;
         end
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_data.valid = rd_valid_ff;
   assign rd_data.entry = rd_entry_ff;

endmodule

// ----- design/ccrg_cmp.sv -----
module ccrg_cmp (
   input  logic [ccrg_pkg::CMP_BITS-1:0] op_a,
   input  logic [ccrg_pkg::CMP_BITS-1:0] op_b,
   output ccrg_pkg::cmp_type             result
);

   // unsigned magnitude compare, shared by the UID scan and counter checks
   assign result.eq = (op_a == op_b);
   assign result.lt = (op_a < op_b);

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;

   // Run bounds. The slowest legal run is roughly 1930 taps plus random stalls
   // and one long receiver hold, well under CYCLE_LIMIT.
   localparam int CYCLE_LIMIT = 400_000;
   localparam int CARD_POOL   = 16;   // cards that are expected to live in the table
   localparam int HOLD_CYCLES = 300;  // long receiver hold-off
   localparam int IDLE_PCT    = 13;

   // ------------------------------------------------------------------
   // DUT connections; every input is known from time zero
   // ------------------------------------------------------------------
   logic                               clock       = 1'b0;
   logic                               reset       = 1'b1;
   logic                               req_valid   = 1'b0;
   logic                               req_ready;
   ccrg_pkg::req_type                  req_data    = '0;
   logic                               rsp_valid;
   logic                               rsp_ready   = 1'b0;
   ccrg_pkg::rsp_type                  rsp_data;
   logic                               csr_psel    = 1'b0;
   logic                               csr_penable = 1'b0;
   logic                               csr_pwrite  = 1'b0;
   logic [ccrg_pkg::CSR_ADDR_BITS-1:0] csr_paddr   = '0;
   logic [ccrg_pkg::CSR_DATA_BITS-1:0] csr_pwdata  = '0;
   logic [ccrg_pkg::CSR_DATA_BITS-1:0] csr_prdata;
   logic                               csr_pready;

   card_counter_replay_guard u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Bookkeeping
   // ------------------------------------------------------------------
   ccrg_pkg::req_type card_events[$];        // taps waiting for the driver
   ccrg_pkg::rsp_type pending_decisions[$];  // predicted decisions, oldest first
   ccrg_pkg::rsp_type want_rsp;

   int  taps_taken     = 0;
   int  decisions_seen = 0;
   int  errors_seen    = 0;
   int  cycle_count    = 0;
   int  reason_hits [8] = '{default: 0};
   logic req_taken     = 1'b0;     // req transfer happened at the last rising edge

   // Both sides stop idling for a stretch in the middle of the run.
   logic quiet_span;
   assign quiet_span = (taps_taken >= 1200) && (taps_taken < 1500);

   // ------------------------------------------------------------------
   // Decision predictor: own copy of the card table and max_counter
   // ------------------------------------------------------------------
   logic                              tbl_valid [ccrg_pkg::ENTRIES] = '{default: 1'b0};
   logic [ccrg_pkg::UID_BITS-1:0]     tbl_uid   [ccrg_pkg::ENTRIES] = '{default: '0};
   logic [ccrg_pkg::COUNTER_BITS-1:0] tbl_ctr   [ccrg_pkg::ENTRIES] = '{default: '0};
   logic [1:0]                        tbl_stat  [ccrg_pkg::ENTRIES] = '{default: '0};
   logic [ccrg_pkg::COUNTER_BITS-1:0] max_counter_cfg = '1;

   function automatic ccrg_pkg::rsp_type judge_tap(ccrg_pkg::req_type tap);
      ccrg_pkg::rsp_type r;
      int      hit;
      int      slot;
      logic    too_big;
      hit  = -1;
      slot = -1;
      // lowest matching entry, lowest free slot
      for (int i = ccrg_pkg::ENTRIES - 1; i >= 0; i--) begin
         if (tbl_valid[i] && tbl_uid[i] == tap.card_uid) hit = i;
         if (!tbl_valid[i]) slot = i;
      end
      too_big = (max_counter_cfg == '0) || (tap.card_counter > max_counter_cfg - 1'b1);

      r.allow         = 1'b0;
      r.reason        = ccrg_pkg::RSN_NONE;
      r.prior_count   = tap.card_counter;
      r.next_count    = tap.card_counter;
      r.entry_written = 1'b0;

      if (tap.func == ccrg_pkg::FUNC_BLOCK) begin
         // window is ignored for a block request
         if (hit >= 0) begin
            tbl_stat[hit]   = ccrg_pkg::STAT_BLOCKED;
            r.reason        = ccrg_pkg::RSN_BLOCKED;
            r.prior_count   = tbl_ctr[hit];
            r.next_count    = tbl_ctr[hit];
            r.entry_written = 1'b1;
         end else if (slot < 0) begin
            r.reason = ccrg_pkg::RSN_FULL;
         end else begin
            tbl_valid[slot] = 1'b1;
            tbl_uid[slot]   = tap.card_uid;
            tbl_ctr[slot]   = tap.card_counter;
            tbl_stat[slot]  = ccrg_pkg::STAT_BLOCKED;
            r.reason        = ccrg_pkg::RSN_BLOCKED;
            r.entry_written = 1'b1;
         end
         return r;
      end

      if (!tap.time_allowed) begin
         r.reason = ccrg_pkg::RSN_TIME;
         return r;
      end

      if (hit >= 0) begin
         r.prior_count = tbl_ctr[hit];
         r.next_count  = tbl_ctr[hit];
         // status first, then replay / regression, then overflow
         if (tbl_stat[hit] >= ccrg_pkg::STAT_COMPROMISED) begin
            r.reason = ccrg_pkg::RSN_COMPROMISED;
            return r;
         end
         if (tbl_stat[hit] == ccrg_pkg::STAT_BLOCKED) begin
            r.reason = ccrg_pkg::RSN_BLOCKED;
            return r;
         end
         if (tap.card_counter <= tbl_ctr[hit]) begin
            tbl_stat[hit]   = ccrg_pkg::STAT_COMPROMISED;
            r.reason        = (tap.card_counter == tbl_ctr[hit]) ? ccrg_pkg::RSN_REPLAY
                                                                 : ccrg_pkg::RSN_REGRESSION;
            r.entry_written = 1'b1;
            return r;
         end
         if (too_big) begin
            r.reason = ccrg_pkg::RSN_OVERFLOW;
            return r;
         end
         slot = hit;
      end else begin
         // unknown card: overflow, then room in the table
         if (too_big) begin
            r.reason = ccrg_pkg::RSN_OVERFLOW;
            return r;
         end
         if (slot < 0) begin
            r.reason = ccrg_pkg::RSN_FULL;
            return r;
         end
      end

      tbl_valid[slot] = 1'b1;
      tbl_uid[slot]   = tap.card_uid;
      tbl_ctr[slot]   = tap.card_counter + 1'b1;
      tbl_stat[slot]  = ccrg_pkg::STAT_OK;
      r.allow         = 1'b1;
      r.prior_count   = tap.card_counter;
      r.next_count    = tap.card_counter + 1'b1;
      r.entry_written = 1'b1;
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Sampling at the rising edge: predict on req transfer, check on rsp
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            pending_decisions.push_back(judge_tap(req_data));
            taps_taken++;
         end
         if (rsp_valid && rsp_ready) begin
            decisions_seen++;
            if (pending_decisions.size() == 0) begin
               $error("decision transfer with nothing pending: %p", rsp_data);
               errors_seen++;
            end else begin
               want_rsp = pending_decisions.pop_front();
               reason_hits[rsp_data.reason]++;
               if (rsp_data.allow !== want_rsp.allow) begin
                  $error("allow: expected %0d, got %0d", want_rsp.allow, rsp_data.allow);
                  errors_seen++;
               end
               if (rsp_data.reason !== want_rsp.reason) begin
                  $error("reason: expected %0d, got %0d", want_rsp.reason, rsp_data.reason);
                  errors_seen++;
               end
               if (rsp_data.prior_count !== want_rsp.prior_count) begin
                  $error("prior_count: expected %h, got %h",
                         want_rsp.prior_count, rsp_data.prior_count);
                  errors_seen++;
               end
               if (rsp_data.next_count !== want_rsp.next_count) begin
                  $error("next_count: expected %h, got %h",
                         want_rsp.next_count, rsp_data.next_count);
                  errors_seen++;
               end
               if (rsp_data.entry_written !== want_rsp.entry_written) begin
                  $error("entry_written: expected %0d, got %0d",
                         want_rsp.entry_written, rsp_data.entry_written);
                  errors_seen++;
               end
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Tap driver, falling edge. Valid holds with stable data until the
   // transfer; between taps it idles at random.
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (card_events.size() != 0 && (quiet_span || $urandom_range(0, 99) >= IDLE_PCT)) begin
            req_valid <= 1'b1;
            req_data  <= card_events.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // Decision receiver, falling edge. Random stalls, plus one long hold
   // while taps keep coming so the block backs up and drops req_ready.
   // ------------------------------------------------------------------
   int   hold_left = 0;
   logic hold_done = 1'b0;

   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else if (!hold_done && decisions_seen >= 300) begin
         rsp_ready <= 1'b0;
         hold_left = HOLD_CYCLES - 1;
         hold_done = 1'b1;
      end else begin
         rsp_ready <= quiet_span || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   logic [ccrg_pkg::UID_BITS-1:0] pool_uid  [CARD_POOL];
   logic [63:0]                   pool_last [CARD_POOL];  // last counter sent per card

   function automatic logic [ccrg_pkg::UID_BITS-1:0] rand_uid();
      logic [63:0] bits64;
      bits64 = {$urandom, $urandom};
      return bits64[ccrg_pkg::UID_BITS-1:0];
   endfunction

   task automatic push_tap(input logic f, input logic [ccrg_pkg::UID_BITS-1:0] uid,
                           input logic [ccrg_pkg::COUNTER_BITS-1:0] ctr, input logic win);
      ccrg_pkg::req_type t;
      t.func         = f;
      t.card_uid     = uid;
      t.card_counter = ctr;
      t.time_allowed = win;
      card_events.push_back(t);
   endtask

   // max_counter write in setup/access cycles, then read back
   task automatic csr_set_max_counter(input logic [ccrg_pkg::COUNTER_BITS-1:0] value);
      logic [ccrg_pkg::CSR_DATA_BITS-1:0] rd;
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ccrg_pkg::CSR_MAX_COUNTER;
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      max_counter_cfg = value;
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      rd = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (rd !== value) begin
         $error("max_counter readback: expected %h, got %h", value, rd);
         errors_seen++;
      end
   endtask

   // Block is idle once every tap went out and every decision came back;
   // each tap yields exactly one decision.
   task automatic wait_drained();
      while (card_events.size() != 0 || req_valid || pending_decisions.size() != 0)
         @(posedge clock);
   endtask

   // Random traffic, mostly well-formed taps on known cards (strictly rising
   // counters, at least two apart so the stored next-counter is passed).
   // Cards 0..7 are kept healthy; 8..15 take replays, regressions and blocks.
   // any_pct lets that abuse reach the healthy cards too.
   task automatic gen_tap_mix(input int n, input int any_pct);
      int          pick;
      int          k;
      logic [63:0] c;
      for (int j = 0; j < n; j++) begin
         pick = $urandom_range(0, 99);
         k    = $urandom_range(0, CARD_POOL - 1);
         if (pick < 68) begin
            c = pool_last[k] + 2 + (($urandom_range(0, 19) == 0) ? $urandom_range(0, 65535)
                                                                : $urandom_range(0, 300));
            if (c > 64'hFFFF_FFFF) c = 64'hFFFF_FFFF;
            else pool_last[k] = c;
            push_tap(ccrg_pkg::FUNC_PRESENT, pool_uid[k], c[31:0],
                     $urandom_range(0, 19) != 0);
         end else if (pick < 76) begin
            push_tap(ccrg_pkg::FUNC_PRESENT, pool_uid[k], $urandom, 1'b0);
         end else if (pick < 82) begin
            if (k < 8) begin
               // healthy card: only counters that must overflow
               c = {32'h0, max_counter_cfg} +
                   ({32'h0, $urandom} % (64'h1_0000_0000 - {32'h0, max_counter_cfg}));
            end else begin
               case ($urandom_range(0, 3))
                  0:       c = {32'h0, max_counter_cfg - 32'd1};
                  1:       c = {32'h0, max_counter_cfg};
                  2:       c = 64'hFFFF_FFFF;
                  default: c = {32'h0, $urandom};
               endcase
               if (c > pool_last[k]) pool_last[k] = c;
            end
            push_tap(ccrg_pkg::FUNC_PRESENT, pool_uid[k], c[31:0], 1'b1);
         end else if (pick < 87) begin
            push_tap(ccrg_pkg::FUNC_PRESENT, rand_uid(), $urandom, 1'($urandom_range(0, 1)));
         end else if (pick < 90) begin
            push_tap(ccrg_pkg::FUNC_BLOCK, rand_uid(), $urandom, 1'($urandom_range(0, 1)));
         end else begin
            if ($urandom_range(0, 99) >= any_pct) k = $urandom_range(8, CARD_POOL - 1);
            case ($urandom_range(0, 2))
               0: begin  // replay of the stored next-counter
                  c = pool_last[k] + 1;
                  push_tap(ccrg_pkg::FUNC_PRESENT, pool_uid[k], c[31:0], 1'b1);
               end
               1: begin  // rollback
                  c = {32'h0, $urandom} % (pool_last[k] + 1);
                  push_tap(ccrg_pkg::FUNC_PRESENT, pool_uid[k], c[31:0], 1'b1);
               end
               default: push_tap(ccrg_pkg::FUNC_BLOCK, pool_uid[k], $urandom,
                                 1'($urandom_range(0, 1)));
            endcase
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------
   initial begin
      for (int i = 0; i < CARD_POOL; i++) begin
         pool_uid[i]  = rand_uid();
         pool_last[i] = 64'($urandom_range(1000, 32'h7FFF_FFFF));
      end
      pool_uid[1]  = '0;   // lowest UID
      pool_uid[13] = '1;   // highest UID

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // max_counter at all ones
      csr_set_max_counter('1);

      // directed taps
      push_tap(ccrg_pkg::FUNC_PRESENT, pool_uid[0], 32'd0, 1'b1);          // new card, zero
      push_tap(ccrg_pkg::FUNC_PRESENT, pool_uid[0], 32'hFFFF_FFFF, 1'b1);  // known overflow
      push_tap(ccrg_pkg::FUNC_PRESENT, pool_uid[0], 32'd5, 1'b0);          // outside window
      push_tap(ccrg_pkg::FUNC_PRESENT, pool_uid[0], 32'd5, 1'b1);          // allow
      push_tap(ccrg_pkg::FUNC_PRESENT, pool_uid[13], 32'hFFFF_FFFF, 1'b1); // unknown overflow
      push_tap(ccrg_pkg::FUNC_BLOCK,   pool_uid[8], 32'h1234, 1'b0);       // block unknown
      push_tap(ccrg_pkg::FUNC_PRESENT, pool_uid[8], 32'h2000, 1'b1);       // blocked card
      push_tap(ccrg_pkg::FUNC_PRESENT, pool_uid[9], 32'd100, 1'b1);
      push_tap(ccrg_pkg::FUNC_PRESENT, pool_uid[9], 32'd101, 1'b1);        // replay
      push_tap(ccrg_pkg::FUNC_PRESENT, pool_uid[9], 32'd500, 1'b1);        // compromised
      push_tap(ccrg_pkg::FUNC_BLOCK,   pool_uid[9], 32'd0, 1'b1);          // block compromised
      push_tap(ccrg_pkg::FUNC_PRESENT, pool_uid[10], 32'd100, 1'b1);
      push_tap(ccrg_pkg::FUNC_PRESENT, pool_uid[10], 32'd50, 1'b1);        // regression
      push_tap(ccrg_pkg::FUNC_PRESENT, pool_uid[11], 32'hFFFF_FFFE, 1'b1); // top allowed
      push_tap(ccrg_pkg::FUNC_PRESENT, pool_uid[11], 32'hFFFF_FFFF, 1'b1); // replay first
      push_tap(ccrg_pkg::FUNC_PRESENT, pool_uid[12], 32'd7, 1'b1);
      push_tap(ccrg_pkg::FUNC_BLOCK,   pool_uid[12], 32'd0, 1'b1);         // block healthy
      push_tap(ccrg_pkg::FUNC_PRESENT, pool_uid[1], 32'd0, 1'b1);          // UID zero

      // register the rest of the pool; this fills the table
      for (int i = 2; i < 8; i++)
         push_tap(ccrg_pkg::FUNC_PRESENT, pool_uid[i], pool_last[i][31:0], 1'b1);
      for (int i = 13; i < CARD_POOL; i++)
         push_tap(ccrg_pkg::FUNC_PRESENT, pool_uid[i], pool_last[i][31:0], 1'b1);

      gen_tap_mix(800, 0);
      wait_drained();

      // zero max_counter: every counter overflows, so no tap is allowed
      csr_set_max_counter('0);
      push_tap(ccrg_pkg::FUNC_PRESENT, rand_uid(), 32'd0, 1'b1);
      gen_tap_mix(150, 0);
      wait_drained();

      // mid-range limit, some healthy cards go over it
      csr_set_max_counter($urandom_range(32'h4000_0000, 32'h7000_0000));
      gen_tap_mix(400, 0);
      wait_drained();

      // only counter zero passes
      csr_set_max_counter(32'd1);
      gen_tap_mix(100, 0);
      wait_drained();

      // back to all ones, abuse may now hit healthy cards
      csr_set_max_counter('1);
      gen_tap_mix(450, 20);
      wait_drained();

      // catch any stray decision
      repeat (50) @(posedge clock);

      $display("Ran %0d card taps under max_counter all ones, zero, mid-range and one.",
               taps_taken);
      $display("Decisions: allow %0d, window %0d, compromised %0d, blocked %0d",
               reason_hits[ccrg_pkg::RSN_NONE], reason_hits[ccrg_pkg::RSN_TIME],
               reason_hits[ccrg_pkg::RSN_COMPROMISED], reason_hits[ccrg_pkg::RSN_BLOCKED]);
      $display("   replay %0d, regression %0d, overflow %0d, full %0d",
               reason_hits[ccrg_pkg::RSN_REPLAY], reason_hits[ccrg_pkg::RSN_REGRESSION],
               reason_hits[ccrg_pkg::RSN_OVERFLOW], reason_hits[ccrg_pkg::RSN_FULL]);
      if (errors_seen == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
